FILE: rtl/lpbd_pkg.sv
// Shared types and codes for the LRU page buffer directory.
package lpbd_pkg;

    localparam logic [1:0] CMD_GET    = 2'd0;
    localparam logic [1:0] CMD_INVAL  = 2'd1;
    localparam logic [1:0] CMD_SHRINK = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [2:0] EV_HIT    = 3'd0;
    localparam logic [2:0] EV_MISS   = 3'd1;
    localparam logic [2:0] EV_EVICT  = 3'd2;
    localparam logic [2:0] EV_INVAL  = 3'd3;
    localparam logic [2:0] EV_ABSENT = 3'd4;
    localparam logic [2:0] EV_SHRINK = 3'd5;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  table_id;
        logic [31:0] page_number;
        logic [4:0]  target_pages;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  event_table;
        logic [31:0] event_page;
        logic [4:0]  occupancy;
        logic        last;
    } t_res;

endpackage

FILE: rtl/lpbd_front.sv
// Command intake: drops unused codes and queues the rest for the engine.
module lpbd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  lpbd_pkg::t_cmd i_cmd,
    output logic           o_cmd_valid,
    output lpbd_pkg::t_cmd o_cmd,
    input  logic           i_cmd_take
);
    import lpbd_pkg::*;

    // two-entry command queue
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    t_cmd       r_q [2];
    logic       w_in;
    logic       w_keep;

    assign o_full      = (r_cnt == 2'd2);
    assign w_in        = i_push && !o_full;
    // drop the unused command code
    assign w_keep      = w_in && (i_cmd.command != CMD_NONE);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_keep) begin
                r_wr <= ~r_wr;
            end
            if (i_cmd_take && o_cmd_valid) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_keep} - {1'b0, i_cmd_take && o_cmd_valid};
        end
    end

    // hold queued payload
    always_ff @(posedge i_clk) begin
        if (w_keep) begin
            r_q[r_wr] <= i_cmd;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_no_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |-> !o_cmd_valid) else $error("valid while empty");
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in && i_cmd.command == CMD_NONE && !(i_cmd_take && o_cmd_valid)) |=> $stable(r_cnt))
        else $error("unused command queued");
endmodule

FILE: rtl/lpbd_back.sv
// Directory engine: lookup, LRU scan, eviction, insertion and result output.
module lpbd_back #(
    parameter int ENTRIES    = 16,
    parameter int STAMP_BITS = 48
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  lpbd_pkg::t_cmd i_cmd,
    output logic           o_cmd_take,
    input  logic [4:0]     i_capacity,
    output logic           o_res_valid,
    output lpbd_pkg::t_res o_res,
    input  logic           i_res_take
);
    import lpbd_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DEC   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_RDV   = 3'd5;

    logic [2:0]            r_st;
    t_cmd                  r_cmd;
    logic [ENTRIES-1:0]    r_valid;
    logic [7:0]            r_tab  [ENTRIES];
    logic [31:0]           r_pg   [ENTRIES];
    logic [STAMP_BITS-1:0] r_stmp [ENTRIES];
    logic [STAMP_BITS-1:0] r_ctr;
    logic [CW-1:0]         r_held;
    logic [IW:0]           r_i;
    logic                  r_bfound;
    logic [IW-1:0]         r_best;
    logic [STAMP_BITS-1:0] r_bstamp;
    logic                  r_hit;
    logic [IW-1:0]         r_hidx;
    logic                  r_evict_then_miss;
    logic                  r_ovalid;
    t_res                  r_res;

    logic [IW-1:0]         w_idx;
    logic                  w_match;
    logic                  w_out_free;
    logic [CW-1:0]         w_cap;
    logic [IW-1:0]         w_free;
    logic [STAMP_BITS-1:0] w_ns;
    logic                  w_evict_first;
    logic                  w_load;

    assign w_idx      = r_i[IW-1:0];
    assign w_match    = r_valid[w_idx] && r_tab[w_idx] == r_cmd.table_id
                        && r_pg[w_idx] == r_cmd.page_number;
    assign w_out_free = !r_ovalid || i_res_take;
    assign o_res_valid = r_ovalid;
    assign o_res       = r_res;
    assign o_cmd_take  = (r_st == S_IDLE) && i_cmd_valid;
    assign w_ns        = r_ctr + {{(STAMP_BITS-1){1'b0}}, 1'b1};

    // a full directory on a miss evicts once before the insertion
    assign w_evict_first = (r_cmd.command == CMD_GET) && !r_hit && !r_evict_then_miss
                           && (r_held >= w_cap);
    // load a result into the output register
    assign w_load = w_out_free
                    && ((r_st == S_RDV) || ((r_st == S_EMIT) && !w_evict_first));

    // clamp capacity to 1..ENTRIES
    always_comb begin
        if (i_capacity == 5'd0) begin
            w_cap = CW'(1);
        end else if (32'(i_capacity) > ENTRIES) begin
            w_cap = CW'(ENTRIES);
        end else begin
            w_cap = CW'(i_capacity);
        end
    end

    // lowest invalid slot
    always_comb begin
        w_free = '0;
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                w_free = IW'(k);
            end
        end
    end

    // sequence one command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_valid  <= '0;
            r_ctr    <= '0;
            r_held   <= '0;
            r_ovalid <= 1'b0;
            r_i      <= '0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_res_take) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_i   <= '0;
                        r_hit <= 1'b0;
                        r_bfound <= 1'b0;
                        r_evict_then_miss <= 1'b0;
                        r_st  <= (i_cmd.command == CMD_SHRINK) ? S_DEC : S_FIND;
                    end
                end
                S_FIND: begin
                    // one entry per cycle
                    if (w_match) begin
                        r_hit  <= 1'b1;
                        r_hidx <= w_idx;
                    end
                    if (r_i == (IW+1)'(ENTRIES - 1)) begin
                        r_st <= S_EMIT;
                    end else begin
                        r_i <= r_i + (IW+1)'(1);
                    end
                end
                S_DEC: begin
                    // shrink loop head
                    r_i      <= '0;
                    r_bfound <= 1'b0;
                    if (32'(r_held) > 32'(r_cmd.target_pages)) begin
                        r_st <= S_SCAN;
                    end else begin
                        r_st <= S_EMIT;
                    end
                end
                S_SCAN: begin
                    if (r_valid[w_idx] && (!r_bfound || r_stmp[w_idx] < r_bstamp)) begin
                        r_bfound <= 1'b1;
                        r_best   <= w_idx;
                        r_bstamp <= r_stmp[w_idx];
                    end
                    if (r_i == (IW+1)'(ENTRIES - 1)) begin
                        r_st <= S_RDV;
                    end else begin
                        r_i <= r_i + (IW+1)'(1);
                    end
                end
                S_RDV: begin
                    // emit eviction
                    if (w_out_free) begin
                        r_res.event_res   <= EV_EVICT;
                        r_res.event_table <= r_tab[r_best];
                        r_res.event_page  <= r_pg[r_best];
                        r_res.occupancy   <= 5'(r_held - CW'(1));
                        r_res.last        <= 1'b0;
                        r_valid[r_best]   <= 1'b0;
                        r_held            <= r_held - CW'(1);
                        r_st <= (r_cmd.command == CMD_SHRINK) ? S_DEC : S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        if (w_evict_first) begin
                            // evict first, then come back for insertion
                            r_evict_then_miss <= 1'b1;
                            r_i      <= '0;
                            r_bfound <= 1'b0;
                            r_st     <= S_SCAN;
                        end else begin
                            r_res.last <= 1'b1;
                            r_st       <= S_IDLE;
                            if (r_cmd.command == CMD_SHRINK) begin
                                r_res.event_res   <= EV_SHRINK;
                                r_res.event_table <= '0;
                                r_res.event_page  <= '0;
                                r_res.occupancy   <= 5'(r_held);
                            end else if (r_cmd.command == CMD_INVAL) begin
                                r_res.event_table <= r_cmd.table_id;
                                r_res.event_page  <= r_cmd.page_number;
                                if (r_hit) begin
                                    r_valid[r_hidx]  <= 1'b0;
                                    r_held           <= r_held - CW'(1);
                                    r_res.event_res  <= EV_INVAL;
                                    r_res.occupancy  <= 5'(r_held - CW'(1));
                                end else begin
                                    r_res.event_res  <= EV_ABSENT;
                                    r_res.occupancy  <= 5'(r_held);
                                end
                            end else if (r_hit) begin
                                r_stmp[r_hidx]    <= w_ns;
                                r_ctr             <= w_ns;
                                r_res.event_res   <= EV_HIT;
                                r_res.event_table <= r_cmd.table_id;
                                r_res.event_page  <= r_cmd.page_number;
                                r_res.occupancy   <= 5'(r_held);
                            end else begin
                                r_valid[w_free]   <= 1'b1;
                                r_tab[w_free]     <= r_cmd.table_id;
                                r_pg[w_free]      <= r_cmd.page_number;
                                r_stmp[w_free]    <= w_ns;
                                r_ctr             <= w_ns;
                                r_held            <= r_held + CW'(1);
                                r_res.event_res   <= EV_MISS;
                                r_res.event_table <= r_cmd.table_id;
                                r_res.event_page  <= r_cmd.page_number;
                                r_res.occupancy   <= 5'(r_held + CW'(1));
                            end
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_held) <= ENTRIES) else $error("occupancy above entry count");
    a_held_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'($countones(r_valid)) == 32'(r_held)) else $error("occupancy mismatch");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> r_st == S_IDLE) else $error("command taken while busy");
endmodule

FILE: rtl/lru_page_buffer_directory_unit.sv
// Top level of the LRU page buffer directory.
//  channel | direction | handshake           | payload
//  command | in        | push / full         | command, table_id, page_number, target_pages
//  result  | out       | empty / pop         | event_res, event_table, event_page, occupancy, last
//  config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (capacity in pages)
// Hit, invalidate, plain miss: one lookup pass over the entries, one entry a cycle.
// Miss with eviction: the lookup pass, then a stamp scan; each shrink eviction is one scan.
// The stamp scan walks the whole entry array to find the oldest valid entry.
// Synchronous active-low reset clears valid bits, occupancy, stamp counter, capacity to 16.
// A held result stalls the engine; a two-deep command queue decouples intake.
module lru_page_buffer_directory_unit #(
    parameter int ENTRIES    = 16,
    parameter int STAMP_BITS = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_table_id,
    input  logic [31:0] i_page_number,
    input  logic [4:0]  i_target_pages,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_event_table,
    output logic [31:0] o_event_page,
    output logic [4:0]  o_occupancy,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);
    import lpbd_pkg::*;

    t_cmd       w_cmd_in;
    t_cmd       w_cmd;
    t_res       w_res;
    logic       w_cmd_valid;
    logic       w_cmd_take;
    logic       w_res_valid;
    logic [4:0] r_capacity;

    assign w_cmd_in = '{command: i_command, table_id: i_table_id,
                        page_number: i_page_number, target_pages: i_target_pages};
    assign o_cfg_ready = 1'b1;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 5'd16;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    lpbd_front u_front (
        .i_clk, .i_rst_n,
        .i_push(push), .o_full(full), .i_cmd(w_cmd_in),
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_take(w_cmd_take)
    );

    lpbd_back #(.ENTRIES(ENTRIES), .STAMP_BITS(STAMP_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd), .o_cmd_take(w_cmd_take),
        .i_capacity(r_capacity),
        .o_res_valid(w_res_valid), .o_res(w_res), .i_res_take(pop && w_res_valid)
    );

    assign empty         = !w_res_valid;
    assign o_event_res   = w_res.event_res;
    assign o_event_table = w_res.event_table;
    assign o_event_page  = w_res.event_page;
    assign o_occupancy   = w_res.occupancy;
    assign o_last        = w_res.last;
endmodule

FILE: tb/sv/tb_lru_page_buffer_directory_unit.sv
// Self-checking testbench for the LRU page buffer directory unit.
module tb_lru_page_buffer_directory_unit;
    import lpbd_pkg::*;

    localparam int NENT = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_command;
    logic [7:0]  i_table_id;
    logic [31:0] i_page_number;
    logic [4:0]  i_target_pages;
    logic        empty;
    logic        pop;
    logic [2:0]  o_event_res;
    logic [7:0]  o_event_table;
    logic [31:0] o_event_page;
    logic [4:0]  o_occupancy;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data;

    lru_page_buffer_directory_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_command(i_command), .i_table_id(i_table_id),
        .i_page_number(i_page_number), .i_target_pages(i_target_pages),
        .empty(empty), .pop(pop),
        .o_event_res(o_event_res), .o_event_table(o_event_table),
        .o_event_page(o_event_page), .o_occupancy(o_occupancy), .o_last(o_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // Generate the clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Directory shadow state
    logic        dir_valid [NENT];
    logic [7:0]  dir_table [NENT];
    logic [31:0] dir_page  [NENT];
    logic [47:0] dir_stamp [NENT];
    logic [47:0] stamp_now;
    int unsigned held_cnt;
    logic [4:0]  cap_reg;

    t_res expected_events[$];
    int   mismatch_cnt;
    bit   quiet_rx;
    int   hold_rx;
    int   idle_pct;

    // Count one mismatch and print it
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_cnt++;
        $display("MISMATCH %s: got %0d want %0d", what, got, want);
    endtask

    function automatic t_res make_event(input logic [2:0] ev, input logic [7:0] tb_id,
                                        input logic [31:0] pg);
        t_res r;
        r.event_res   = ev;
        r.event_table = tb_id;
        r.event_page  = pg;
        r.occupancy   = held_cnt[4:0];
        r.last        = 1'b0;
        return r;
    endfunction

    // Drop the oldest valid entry and return its index, or -1
    function automatic int evict_lru();
        int best;
        best = -1;
        for (int i = 0; i < NENT; i++)
            if (dir_valid[i] && (best < 0 || dir_stamp[i] < dir_stamp[best]))
                best = i;
        if (best >= 0) begin
            dir_valid[best] = 1'b0;
            if (held_cnt > 0) held_cnt--;
        end
        return best;
    endfunction

    // Work out the events caused by one command
    task automatic predict_events(input t_cmd c);
        int idx;
        int v;
        int unsigned cap;
        int first;
        idx = -1;
        first = expected_events.size();
        if (c.command == CMD_GET || c.command == CMD_INVAL)
            for (int i = NENT - 1; i >= 0; i--)
                if (dir_valid[i] && dir_table[i] == c.table_id && dir_page[i] == c.page_number)
                    idx = i;
        if (c.command == CMD_GET) begin
            if (idx >= 0) begin
                stamp_now++;
                dir_stamp[idx] = stamp_now;
                expected_events.push_back(make_event(EV_HIT, c.table_id, c.page_number));
            end else begin
                cap = cap_reg;
                if (cap == 0) cap = 1;
                if (cap > NENT) cap = NENT;
                if (held_cnt >= cap) begin
                    v = evict_lru();
                    if (v >= 0)
                        expected_events.push_back(make_event(EV_EVICT, dir_table[v], dir_page[v]));
                end
                for (int i = 0; i < NENT; i++)
                    if (!dir_valid[i]) begin
                        dir_valid[i] = 1'b1;
                        dir_table[i] = c.table_id;
                        dir_page[i]  = c.page_number;
                        stamp_now++;
                        dir_stamp[i] = stamp_now;
                        held_cnt++;
                        break;
                    end
                expected_events.push_back(make_event(EV_MISS, c.table_id, c.page_number));
            end
        end else if (c.command == CMD_INVAL) begin
            if (idx >= 0) begin
                dir_valid[idx] = 1'b0;
                if (held_cnt > 0) held_cnt--;
                expected_events.push_back(make_event(EV_INVAL, c.table_id, c.page_number));
            end else begin
                expected_events.push_back(make_event(EV_ABSENT, c.table_id, c.page_number));
            end
        end else if (c.command == CMD_SHRINK) begin
            while (held_cnt > c.target_pages) begin
                v = evict_lru();
                if (v < 0) break;
                expected_events.push_back(make_event(EV_EVICT, dir_table[v], dir_page[v]));
            end
            expected_events.push_back(make_event(EV_SHRINK, 8'd0, 32'd0));
        end
        if (expected_events.size() > first)
            expected_events[expected_events.size() - 1].last = 1'b1;
    endtask

    // Transfer one command, idling at random first
    task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] tid,
                            input logic [31:0] pg, input logic [4:0] tgt);
        t_cmd c;
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        c.command = cmd;
        c.table_id = tid;
        c.page_number = pg;
        c.target_pages = tgt;
        push           <= 1'b1;
        i_command      <= cmd;
        i_table_id     <= tid;
        i_page_number  <= pg;
        i_target_pages <= tgt;
        do @(posedge i_clk); while (full);
        predict_events(c);
    endtask

    // Wait until every expected event has arrived, then let the engine settle
    task automatic drain();
        int guard;
        guard = 0;
        push <= 1'b0;
        while (expected_events.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (3 * NENT + 10) @(posedge i_clk);
    endtask

    // Write the capacity register while idle
    task automatic write_capacity(input logic [4:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cap_reg = val;
    endtask

    // Receive side: pop at random and check each transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_events.size() == 0) begin
                    report_mismatch("unexpected event", o_event_res, -1);
                end else begin
                    t_res w;
                    w = expected_events.pop_front();
                    if (o_event_res != w.event_res)
                        report_mismatch("event_res", o_event_res, w.event_res);
                    if (o_event_table != w.event_table)
                        report_mismatch("event_table", o_event_table, w.event_table);
                    if (o_event_page != w.event_page)
                        report_mismatch("event_page", o_event_page, w.event_page);
                    if (o_occupancy != w.occupancy)
                        report_mismatch("occupancy", o_occupancy, w.occupancy);
                    if (o_last != w.last)
                        report_mismatch("last", o_last, w.last);
                end
            end
            if (hold_rx > 0) begin
                hold_rx <= hold_rx - 1;
                pop <= 1'b0;
            end else begin
                pop <= quiet_rx ? 1'b1 : ($urandom_range(99) >= 16);
            end
        end
    end

    task automatic test_extremes();
        send_cmd(CMD_GET, 8'd0, 32'd0, 5'd0);
        send_cmd(CMD_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31);
        send_cmd(CMD_GET, 8'd0, 32'd0, 5'd0);
        send_cmd(CMD_INVAL, 8'hFF, 32'hFFFF_FFFF, 5'd0);
        send_cmd(CMD_INVAL, 8'hFF, 32'hFFFF_FFFF, 5'd0);
        send_cmd(CMD_NONE, 8'hAA, 32'h5555_AAAA, 5'd7);
        send_cmd(CMD_SHRINK, 8'h12, 32'h1234, 5'd16);
        send_cmd(CMD_SHRINK, 8'd0, 32'd0, 5'd0);
    endtask

    // Capacity at zero (clamped to one), above the array and lowered below occupancy
    task automatic test_capacity_limits();
        write_capacity(5'd0);
        for (int i = 0; i < 3; i++) send_cmd(CMD_GET, 8'd1, 32'(i), 5'd0);
        write_capacity(5'd31);
        for (int i = 0; i < 18; i++) send_cmd(CMD_GET, 8'd2, 32'(i), 5'd0);
        write_capacity(5'd4);
        send_cmd(CMD_GET, 8'd3, 32'd9, 5'd0);
        send_cmd(CMD_SHRINK, 8'd0, 32'd0, 5'd2);
    endtask

    // Fill the output while the receiver holds off
    task automatic test_backpressure();
        write_capacity(5'd16);
        hold_rx = 400;
        for (int i = 0; i < 12; i++) send_cmd(CMD_GET, 8'd4, 32'(i), 5'd0);
        send_cmd(CMD_SHRINK, 8'd0, 32'd0, 5'd0);
        drain();
    endtask

    // Random traffic over a small key space so hits and evictions are common
    task automatic test_random(input int count, input logic [4:0] cap);
        logic [1:0] cmd;
        int r;
        write_capacity(cap);
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            cmd = (r < 70) ? CMD_GET : (r < 88) ? CMD_INVAL : (r < 97) ? CMD_SHRINK : CMD_NONE;
            if ($urandom_range(9) == 0)
                send_cmd(cmd, 8'($urandom), 32'($urandom), 5'($urandom));
            else
                send_cmd(cmd, 8'($urandom_range(1)),
                         32'($urandom_range(11) ^ {$urandom_range(1), 31'd0}),
                         5'($urandom_range(16)));
        end
    endtask

    initial begin
        push = 0; pop = 0; i_cfg_valid = 0; i_cfg_data = 0;
        i_command = 0; i_table_id = 0; i_page_number = 0; i_target_pages = 0;
        mismatch_cnt = 0; quiet_rx = 0; hold_rx = 0; idle_pct = 16;
        for (int i = 0; i < NENT; i++) begin
            dir_valid[i] = 0; dir_table[i] = 0; dir_page[i] = 0; dir_stamp[i] = 0;
        end
        stamp_now = 0; held_cnt = 0; cap_reg = 5'd16;
        i_rst_n = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_capacity_limits();
        test_backpressure();
        test_random(140, 5'd16);
        test_random(110, 5'd1);
        idle_pct = 0;
        quiet_rx = 1;
        test_random(100, 5'd5);
        idle_pct = 16;
        quiet_rx = 0;
        test_random(80, 5'd31);
        drain();
        $display("Covered gets, invalidates, shrinks and ignored commands under capacities");
        $display("0, 1, 4, 5, 16 and 31 with random stalls and a long receiver hold-off.");
        if (mismatch_cnt == 0 && expected_events.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Stop a hung run
    initial begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/lpbd_pkg.sv
rtl/lpbd_front.sv
rtl/lpbd_back.sv
rtl/lru_page_buffer_directory_unit.sv
tb/sv/tb_lru_page_buffer_directory_unit.sv
